// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPL(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/fbpa_pkg.sv =====
// ----------------------------------------------------------------------------
// Block pool allocator package
// Field widths, register indexes, status codes and the command record.
// ----------------------------------------------------------------------------
package fbpa_pkg;

    localparam int IDX_W     = 10;
    localparam int POOL_W    = 11;
    localparam int BUMP_W    = 11;
    localparam int SIZE_W    = 16;
    localparam int ADDR_W    = 32;
    localparam int PROD_W    = IDX_W + SIZE_W;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 32;
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 48;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_POOL_BLOCKS  = 2'd0,
        CFG_BLOCK_SIZE   = 2'd1,
        CFG_BASE_ADDRESS = 2'd2
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EXHAUSTED = 2'd1,
        ST_BAD_INDEX = 2'd2,
        ST_OVERFLOW  = 2'd3
    } status_t;

    typedef enum logic {
        REQ_ALLOC = 1'b0,
        REQ_FREE  = 1'b1
    } req_t;

    typedef struct packed {
        logic             valid;
        status_t          status;
        logic             ok;
        logic             from_stack;
        logic [IDX_W-1:0] index;
    } cmd_t;

endpackage

// ===== rtl/fbpa_stack.sv =====
// ----------------------------------------------------------------------------
// Free stack memory
// Single write port and single read port, read data registered.
// ----------------------------------------------------------------------------
module fbpa_stack #(
    parameter int DEPTH = 1024
) (
    input  logic                           clk,
    input  logic                           wr_en,
    input  logic [$clog2(DEPTH)-1:0]       wr_addr,
    input  logic [fbpa_pkg::IDX_W-1:0]     wr_data,
    input  logic                           rd_en,
    input  logic [$clog2(DEPTH)-1:0]       rd_addr,
    output logic [fbpa_pkg::IDX_W-1:0]     rd_data
);

    logic [fbpa_pkg::IDX_W-1:0] stack_reg [DEPTH];
    logic [fbpa_pkg::IDX_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            stack_reg[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= stack_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/fbpa_ctrl.sv =====
// ----------------------------------------------------------------------------
// Allocator control
// Decides each request, keeps the free and bump counts and drives the stack.
// ----------------------------------------------------------------------------
module fbpa_ctrl #(
    parameter int MAX_BLOCKS = 1024
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              req_valid,
    output logic                              req_ready,
    input  logic                              req_type,
    input  logic [fbpa_pkg::IDX_W-1:0]        block_index,
    input  logic [fbpa_pkg::POOL_W-1:0]       pool_blocks,
    input  logic                              addr_busy,
    output logic                              wr_en,
    output logic [$clog2(MAX_BLOCKS)-1:0]     wr_addr,
    output logic [fbpa_pkg::IDX_W-1:0]        wr_data,
    output logic                              rd_en,
    output logic [$clog2(MAX_BLOCKS)-1:0]     rd_addr,
    output fbpa_pkg::cmd_t                    cmd
);

    localparam int AW    = $clog2(MAX_BLOCKS);
    localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
    localparam int LIM_W = (CNT_W > fbpa_pkg::POOL_W) ? CNT_W : fbpa_pkg::POOL_W;

    logic [CNT_W-1:0]            free_count_reg, free_count_next;
    logic [fbpa_pkg::BUMP_W-1:0] bump_count_reg, bump_count_next;
    fbpa_pkg::cmd_t              cmd_reg, cmd_next;

    logic             accept;
    logic             pop;
    logic             push;
    logic             bump;
    logic [LIM_W-1:0] pool_ext;
    logic [LIM_W-1:0] max_ext;
    logic [LIM_W-1:0] limit;
    logic [CNT_W-1:0] free_dec;
    fbpa_pkg::status_t status;

    assign req_ready = !cmd_reg.valid && !addr_busy;
    assign accept    = req_valid && req_ready;

    assign pool_ext = LIM_W'(pool_blocks);
    assign max_ext  = LIM_W'(MAX_BLOCKS);
    assign limit    = (pool_ext < max_ext) ? pool_ext : max_ext;
    assign free_dec = free_count_reg - CNT_W'(1);

    always_comb
    begin
        pop    = 1'b0;
        push   = 1'b0;
        bump   = 1'b0;
        status = fbpa_pkg::ST_OK;
        if (req_type == fbpa_pkg::REQ_ALLOC)
        begin
            if (free_count_reg != '0)
            begin
                pop = 1'b1;
            end
            else if (LIM_W'(bump_count_reg) >= limit)
            begin
                status = fbpa_pkg::ST_EXHAUSTED;
            end
            else
            begin
                bump = 1'b1;
            end
        end
        else
        begin
            if (LIM_W'(block_index) >= limit)
            begin
                status = fbpa_pkg::ST_BAD_INDEX;
            end
            else if (free_count_reg == CNT_W'(MAX_BLOCKS))
            begin
                status = fbpa_pkg::ST_OVERFLOW;
            end
            else
            begin
                push = 1'b1;
            end
        end
    end

    always_comb
    begin
        free_count_next = free_count_reg;
        bump_count_next = bump_count_reg;
        cmd_next        = cmd_reg;
        cmd_next.valid  = 1'b0;
        if (accept)
        begin
            if (pop)
            begin
                free_count_next = free_dec;
            end
            if (push)
            begin
                free_count_next = free_count_reg + CNT_W'(1);
            end
            if (bump)
            begin
                bump_count_next = bump_count_reg + fbpa_pkg::BUMP_W'(1);
            end
            cmd_next.valid      = 1'b1;
            cmd_next.status     = status;
            cmd_next.ok         = pop || push || bump;
            cmd_next.from_stack = pop;
            if (push)
            begin
                cmd_next.index = block_index;
            end
            else if (bump)
            begin
                cmd_next.index = bump_count_reg[fbpa_pkg::IDX_W-1:0];
            end
            else
            begin
                cmd_next.index = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_count_reg <= '0;
            bump_count_reg <= '0;
            cmd_reg        <= '0;
        end
        else
        begin
            free_count_reg <= free_count_next;
            bump_count_reg <= bump_count_next;
            cmd_reg        <= cmd_next;
        end
    end

    assign wr_en   = accept && push;
    assign wr_addr = free_count_reg[AW-1:0];
    assign wr_data = block_index;
    assign rd_en   = accept && pop;
    assign rd_addr = free_dec[AW-1:0];
    assign cmd     = cmd_reg;

endmodule

// ===== rtl/fbpa_addr.sv =====
// ----------------------------------------------------------------------------
// Address unit
// Multiplies the granted index by the block size, adds the base if the request
// succeeded (else gives zero) and holds the result in the output register.
// ----------------------------------------------------------------------------
module fbpa_addr (
    input  logic                           clk,
    input  logic                           rst_n,
    input  fbpa_pkg::cmd_t                 cmd,
    input  logic [fbpa_pkg::IDX_W-1:0]     rd_data,
    input  logic [fbpa_pkg::SIZE_W-1:0]    block_size,
    input  logic [fbpa_pkg::ADDR_W-1:0]    base_address,
    output logic                           busy,
    output logic                           res_valid,
    input  logic                           res_ready,
    output fbpa_pkg::status_t              res_status,
    output logic [fbpa_pkg::IDX_W-1:0]     res_index,
    output logic [fbpa_pkg::ADDR_W-1:0]    res_address
);

    logic                           mul_valid_reg, mul_valid_next;
    fbpa_pkg::status_t              mul_status_reg;
    logic                           mul_ok_reg;
    logic [fbpa_pkg::IDX_W-1:0]     mul_index_reg;
    logic [fbpa_pkg::PROD_W-1:0]    prod_reg;

    logic                           out_valid_reg, out_valid_next;
    fbpa_pkg::status_t              out_status_reg;
    logic [fbpa_pkg::IDX_W-1:0]     out_index_reg;
    logic [fbpa_pkg::ADDR_W-1:0]    out_address_reg;

    logic                           mul_adv;
    logic [fbpa_pkg::IDX_W-1:0]     granted;
    logic [fbpa_pkg::PROD_W-1:0]    prod_next;
    logic [fbpa_pkg::ADDR_W-1:0]    addr_next;

    assign mul_adv   = mul_valid_reg && (!out_valid_reg || res_ready);
    assign granted   = cmd.from_stack ? rd_data : cmd.index;
    assign prod_next = fbpa_pkg::PROD_W'(granted) * fbpa_pkg::PROD_W'(block_size);
    assign addr_next = mul_ok_reg ? (base_address + fbpa_pkg::ADDR_W'(prod_reg)) : '0;

    always_comb
    begin
        mul_valid_next = mul_valid_reg;
        if (cmd.valid)
        begin
            mul_valid_next = 1'b1;
        end
        else if (mul_adv)
        begin
            mul_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (mul_adv)
        begin
            out_valid_next = 1'b1;
        end
        else if (res_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mul_valid_reg <= mul_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.valid)
        begin
            mul_status_reg <= cmd.status;
            mul_ok_reg     <= cmd.ok;
            mul_index_reg  <= granted;
            prod_reg       <= prod_next;
        end
        if (mul_adv)
        begin
            out_status_reg  <= mul_status_reg;
            out_index_reg   <= mul_index_reg;
            out_address_reg <= addr_next;
        end
    end

    assign busy        = mul_valid_reg;
    assign res_valid   = out_valid_reg;
    assign res_status  = out_status_reg;
    assign res_index   = out_index_reg;
    assign res_address = out_address_reg;

endmodule

// ===== rtl/fixed_block_pool_allocator.sv =====
// ----------------------------------------------------------------------------
// Fixed block pool allocator
// Hands out and takes back equal blocks through a LIFO free stack in memory
// and a bump counter, and returns each block's byte address.
// ----------------------------------------------------------------------------
// A request is taken only while no earlier one is in the command register or
// the multiply stage. The free stack memory is read or written in the cycle of
// the transfer, the granted index is then multiplied by the block size, and the
// base is added into the output register once it is empty or being read. A
// result waiting in the output register does not hold off the next request.
// The stack memory needs no clearing after reset, so requests are taken at
// once. Each request gives exactly one result; status 0 is success and any
// error leaves the allocator state untouched with index and address zero.
`include "assert_macros.svh"

module fixed_block_pool_allocator #(
    parameter int MAX_BLOCKS = 1024
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // block_index [9:0], zeros above.
    input  logic [fbpa_pkg::S_TDATA_W-1:0]      s_tdata,
    // req_type [0].
    input  logic                                s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // granted_index [9:0], block_address [41:10], zeros above.
    output logic [fbpa_pkg::M_TDATA_W-1:0]      m_tdata,
    // status [1:0].
    output logic [1:0]                          m_tuser,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [fbpa_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [fbpa_pkg::CFG_DAT_W-1:0]      cfg_data
);

    localparam int AW = $clog2(MAX_BLOCKS);

    logic [fbpa_pkg::POOL_W-1:0] pool_blocks_reg;
    logic [fbpa_pkg::SIZE_W-1:0] block_size_reg;
    logic [fbpa_pkg::ADDR_W-1:0] base_address_reg;

    logic                        wr_en;
    logic [AW-1:0]               wr_addr;
    logic [fbpa_pkg::IDX_W-1:0]  wr_data;
    logic                        rd_en;
    logic [AW-1:0]               rd_addr;
    logic [fbpa_pkg::IDX_W-1:0]  rd_data;
    fbpa_pkg::cmd_t              cmd;
    logic                        addr_busy;
    fbpa_pkg::status_t           res_status;
    logic [fbpa_pkg::IDX_W-1:0]  res_index;
    logic [fbpa_pkg::ADDR_W-1:0] res_address;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pool_blocks_reg  <= fbpa_pkg::POOL_W'(1024);
            block_size_reg   <= fbpa_pkg::SIZE_W'(32);
            base_address_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                fbpa_pkg::CFG_POOL_BLOCKS:
                begin
                    pool_blocks_reg <= cfg_data[fbpa_pkg::POOL_W-1:0];
                end
                fbpa_pkg::CFG_BLOCK_SIZE:
                begin
                    block_size_reg <= cfg_data[fbpa_pkg::SIZE_W-1:0];
                end
                fbpa_pkg::CFG_BASE_ADDRESS:
                begin
                    base_address_reg <= cfg_data[fbpa_pkg::ADDR_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    fbpa_ctrl #(
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (s_tvalid),
        .req_ready   (s_tready),
        .req_type    (s_tuser),
        .block_index (s_tdata[fbpa_pkg::IDX_W-1:0]),
        .pool_blocks (pool_blocks_reg),
        .addr_busy   (addr_busy),
        .wr_en       (wr_en),
        .wr_addr     (wr_addr),
        .wr_data     (wr_data),
        .rd_en       (rd_en),
        .rd_addr     (rd_addr),
        .cmd         (cmd)
    );

    fbpa_stack #(
        .DEPTH (MAX_BLOCKS)
    ) u_stack (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    fbpa_addr u_addr (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .rd_data      (rd_data),
        .block_size   (block_size_reg),
        .base_address (base_address_reg),
        .busy         (addr_busy),
        .res_valid    (m_tvalid),
        .res_ready    (m_tready),
        .res_status   (res_status),
        .res_index    (res_index),
        .res_address  (res_address)
    );

    assign m_tuser = res_status;
    assign m_tdata = {
        (fbpa_pkg::M_TDATA_W - fbpa_pkg::IDX_W - fbpa_pkg::ADDR_W)'(0),
        res_address,
        res_index
    };

    `ASSERT_NEXT(a_one_in_flight, s_tvalid && s_tready, !s_tready && cmd.valid, "request taken while another is in flight")
    `ASSERT_NEXT(a_cmd_to_mul, cmd.valid, !cmd.valid && addr_busy, "command did not move into the multiply stage")
    `ASSERT_IMPL(a_err_zero, m_tvalid && (m_tuser != fbpa_pkg::ST_OK), m_tdata == '0, "error result carries nonzero index or address")

endmodule
